@@ design/vtfc_pkg.sv @@
// ----------------------------------------------------------------------------
// vtfc_pkg: shared types and constants for the VGA trace frame capture
// Event codes, config register indexes, gamma tables, queue entry layout and
// the constants of the constant-divisor column computation.
// ----------------------------------------------------------------------------
`default_nettype none

package vtfc_pkg;

  localparam int FRAME_WIDTH  = 800;
  localparam int FRAME_HEIGHT = 522;

  localparam logic [63:0] FS_PER_PIXEL = 64'd40000000;
  localparam logic [63:0] PS_PER_PIXEL = 64'd40000;

  // Elapsed time below this bound lands inside the frame width
  localparam logic [63:0] LIM_FS = 64'(FRAME_WIDTH) * FS_PER_PIXEL;
  localparam logic [63:0] LIM_PS = 64'(FRAME_WIDTH) * PS_PER_PIXEL;

  // Strip the power-of-two factor of the pixel period first
  localparam int SH_FS = 9;
  localparam int SH_PS = 6;
  localparam logic [63:0] DIV_FS = FS_PER_PIXEL >> SH_FS;
  localparam logic [63:0] DIV_PS = PS_PER_PIXEL >> SH_PS;
  localparam int DW = $clog2(DIV_FS + 64'd1);

  // Reduced dividend width for any in-range elapsed time
  localparam int VW = $clog2(64'(FRAME_WIDTH) * DIV_FS);

  // Reciprocal multipliers: estimate is exact or one low
  localparam int RS_FS = VW + 10;
  localparam int RS_PS = VW + 3;
  localparam logic [63:0] M_FS = (64'd1 << RS_FS) / DIV_FS;
  localparam logic [63:0] M_PS = (64'd1 << RS_PS) / DIV_PS;
  localparam int MW = $clog2(((M_FS > M_PS) ? M_FS : M_PS) + 64'd1);
  localparam int PW = VW + MW;
  localparam int QW = $clog2(FRAME_WIDTH + 1);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [9:0] MIN_LINES_RESET = 10'd520;

  typedef enum logic [2:0] {
    CMD_STAMP = 3'd0,
    CMD_HSYNC = 3'd1,
    CMD_VSYNC = 3'd2,
    CMD_RED   = 3'd3,
    CMD_GREEN = 3'd4,
    CMD_BLUE  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_TIME_UNIT  = 2'd0,
    CFG_SINGLE_BIT = 2'd1,
    CFG_MIN_LINES  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FRAME = 1'b1
  } kind_t;

  typedef struct packed {
    logic       time_unit;
    logic       single_bit_colour;
    logic [9:0] min_frame_lines;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [9:0] row;
    logic       row_ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] frame;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [63:0] diff;
  } entry_t;

  localparam logic [7:0] GAMMA3 [8] = '{8'd0, 8'd104, 8'd143, 8'd172,
                                        8'd194, 8'd215, 8'd234, 8'd251};
  localparam logic [7:0] GAMMA2 [4] = '{8'd0, 8'd146, 8'd197, 8'd238};

endpackage

`default_nettype wire

@@ design/vtfc_front.sv @@
// ----------------------------------------------------------------------------
// vtfc_front: event decode and running trace state
// Tracks sync edges, line count, line start time and colour; pushes one
// queue request per timestamp and per frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      command,
  input  logic [2:0]      level,
  input  logic            scalar_event,
  input  logic [63:0]     stamp,
  input  vtfc_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            push,
  output vtfc_pkg::entry_t push_entry
);
  import vtfc_pkg::*;

  logic               hsync_prev, hsync_prev_next;
  logic               vsync_prev, vsync_prev_next;
  logic signed [10:0] line_count, line_count_next;
  logic [63:0]        line_start_time, line_start_time_next;
  logic [63:0]        current_time, current_time_next;
  logic [7:0]         red, red_next;
  logic [7:0]         green, green_next;
  logic [7:0]         blue, blue_next;
  logic [7:0]         frames_done, frames_done_next;
  logic               take;
  logic               row_ok;
  cmd_t               cmd;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign cmd      = cmd_t'(command);
  assign row_ok   = !line_count[10] && (line_count < FRAME_HEIGHT);

  always_comb begin
    hsync_prev_next      = hsync_prev;
    vsync_prev_next      = vsync_prev;
    line_count_next      = line_count;
    line_start_time_next = line_start_time;
    current_time_next    = current_time;
    red_next             = red;
    green_next           = green;
    blue_next            = blue;
    frames_done_next     = frames_done;
    push                 = 1'b0;
    push_entry.meta.kind   = KIND_PIXEL;
    push_entry.meta.row    = line_count[9:0];
    push_entry.meta.row_ok = row_ok;
    push_entry.meta.red    = red;
    push_entry.meta.green  = green;
    push_entry.meta.blue   = blue;
    push_entry.meta.frame  = frames_done;
    push_entry.diff        = current_time - line_start_time;
    if (take) begin
      case (cmd)
        CMD_STAMP: begin
          push              = 1'b1;
          current_time_next = stamp;
        end
        CMD_HSYNC: begin
          // falling edge starts a new line
          if (!level[0] && hsync_prev) begin
            if (line_count < 11'sd1023) line_count_next = line_count + 11'sd1;
            line_start_time_next = current_time;
          end
          hsync_prev_next = level[0];
        end
        CMD_VSYNC: begin
          if (!level[0] && vsync_prev &&
              line_count >= $signed({1'b0, cfg.min_frame_lines})) begin
            push                  = 1'b1;
            push_entry.meta.kind  = KIND_FRAME;
            push_entry.meta.frame = frames_done + 8'd1;
            frames_done_next      = frames_done + 8'd1;
            line_count_next       = -11'sd1;
          end
          vsync_prev_next = level[0];
        end
        CMD_RED: begin
          if (!scalar_event) red_next = GAMMA3[level];
          else if (cfg.single_bit_colour) red_next = level[0] ? GAMMA3[7] : GAMMA3[0];
        end
        CMD_GREEN: begin
          if (!scalar_event) green_next = GAMMA3[level];
          else if (cfg.single_bit_colour) green_next = level[0] ? GAMMA3[7] : GAMMA3[0];
        end
        CMD_BLUE: begin
          if (!scalar_event) blue_next = GAMMA2[level[1:0]];
          else if (cfg.single_bit_colour) blue_next = level[0] ? GAMMA2[3] : GAMMA2[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsync_prev      <= 1'b0;
      vsync_prev      <= 1'b0;
      line_count      <= '0;
      line_start_time <= '0;
      current_time    <= '0;
      red             <= '0;
      green           <= '0;
      blue            <= '0;
      frames_done     <= '0;
    end else begin
      hsync_prev      <= hsync_prev_next;
      vsync_prev      <= vsync_prev_next;
      line_count      <= line_count_next;
      line_start_time <= line_start_time_next;
      current_time    <= current_time_next;
      red             <= red_next;
      green           <= green_next;
      blue            <= blue_next;
      frames_done     <= frames_done_next;
    end
  end

  a_line_floor: assert property (@(posedge clk) disable iff (rst)
    line_count[10] |-> line_count == -11'sd1)
    else $error("line count below minus one");

endmodule

`default_nettype wire

@@ design/vtfc_queue.sv @@
// ----------------------------------------------------------------------------
// vtfc_queue: short request queue between front and back
// Four-entry FIFO with a fill count; head is read combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  vtfc_pkg::entry_t push_entry,
  input  logic             pop,
  output vtfc_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import vtfc_pkg::*;

  entry_t           slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == QCW'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop) rd_ptr <= rd_ptr + QAW'(1);
      if (push && !pop) count <= count + QCW'(1);
      else if (pop && !push) count <= count - QCW'(1);
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCW'(1))
    else $error("fill count did not advance");

endmodule

`default_nettype wire

@@ design/vtfc_back.sv @@
// ----------------------------------------------------------------------------
// vtfc_back: column computation and result register
// Range check, reciprocal multiply, remainder correction, output register.
// All stages advance together whenever the output register can take data.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfc_back (
  input  logic             clk,
  input  logic             rst,
  input  vtfc_pkg::cfg_t   cfg,
  input  vtfc_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             result_kind,
  output logic [9:0]       column,
  output logic [9:0]       row,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic             write_valid,
  output logic [7:0]       frame_number
);
  import vtfc_pkg::*;

  logic           advance;
  logic           head_in_range;
  logic [VW-1:0]  head_v;
  logic [MW-1:0]  mult_sel;
  logic [DW-1:0]  div_sel;

  logic           s1_valid, s2_valid, s3_valid;
  meta_t          s1_meta, s2_meta, s3_meta;
  logic           s1_in_range, s2_in_range, s3_in_range;
  logic [VW-1:0]  s1_v, s2_v, s3_v;
  logic [PW-1:0]  s2_prod;
  logic [QW-1:0]  q_est, s3_q;
  logic [QW+DW-1:0] qm_full;
  logic [VW-1:0]  s3_qm;
  logic [VW-1:0]  rem;
  logic [QW-1:0]  col;
  logic           pix_ok;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !empty;

  assign mult_sel = cfg.time_unit ? MW'(M_PS) : MW'(M_FS);
  assign div_sel  = cfg.time_unit ? DW'(DIV_PS) : DW'(DIV_FS);

  // Drop the power-of-two part of the period; value fits VW when in range
  assign head_in_range = head.diff < (cfg.time_unit ? LIM_PS : LIM_FS);
  assign head_v = cfg.time_unit ? head.diff[SH_PS +: VW] : head.diff[SH_FS +: VW];

  assign q_est   = cfg.time_unit ? QW'(s2_prod >> RS_PS) : QW'(s2_prod >> RS_FS);
  assign qm_full = (QW+DW)'(q_est) * (QW+DW)'(div_sel);

  // Estimate may be one low: correct with the remainder
  assign rem    = s3_v - s3_qm;
  assign col    = (rem >= VW'(div_sel)) ? s3_q + QW'(1) : s3_q;
  assign pix_ok = (s3_meta.kind == KIND_PIXEL) && s3_meta.row_ok && s3_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= !empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_meta     <= head.meta;
      s1_in_range <= head_in_range;
      s1_v        <= head_v;

      s2_meta     <= s1_meta;
      s2_in_range <= s1_in_range;
      s2_v        <= s1_v;
      s2_prod     <= PW'(s1_v) * PW'(mult_sel);

      s3_meta     <= s2_meta;
      s3_in_range <= s2_in_range;
      s3_v        <= s2_v;
      s3_q        <= q_est;
      s3_qm       <= VW'(qm_full);

      result_kind  <= s3_meta.kind;
      column       <= pix_ok ? 10'(col) : 10'd0;
      row          <= (pix_ok || s3_meta.kind == KIND_FRAME) ? s3_meta.row : 10'd0;
      red_out      <= s3_meta.red;
      green_out    <= s3_meta.green;
      blue_out     <= s3_meta.blue;
      write_valid  <= pix_ok;
      frame_number <= s3_meta.frame;
    end
  end

  a_write_inside: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_valid) |-> (result_kind == KIND_PIXEL && column < FRAME_WIDTH
                                    && row < FRAME_HEIGHT))
    else $error("valid write outside the frame");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_FRAME) |-> (column == 10'd0 && !write_valid))
    else $error("frame end carries pixel data");

endmodule

`default_nettype wire

@@ design/vga_trace_frame_capture.sv @@
// Path: an accepted pixel or frame-end event is written to the request queue,
//   then passes stages s1, s2, s3 and the output register; other events give none.
// Throughput: one event per cycle; in_ready drops only when the 4-entry
//   request queue fills behind a stalled output.
// Reset: synchronous; clears trace state, queue and pipeline, and loads the
//   config defaults (fs units, vector colour only, 520 lines per frame).
// ----------------------------------------------------------------------------
// vga_trace_frame_capture: rebuild VGA frames from time-stamped events
// Config registers, event front end, request queue and column back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vga_trace_frame_capture (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [2:0]  level,
  input  logic        scalar_event,
  input  logic [63:0] stamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [9:0]  column,
  output logic [9:0]  row,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        write_valid,
  output logic [7:0]  frame_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import vtfc_pkg::*;

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   pop;
  entry_t head;
  logic   empty;
  logic   full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_unit         <= 1'b0;
      cfg.single_bit_colour <= 1'b0;
      cfg.min_frame_lines   <= MIN_LINES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIME_UNIT:  cfg.time_unit         <= cfg_data[0];
        CFG_SINGLE_BIT: cfg.single_bit_colour <= cfg_data[0];
        CFG_MIN_LINES:  cfg.min_frame_lines   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vtfc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .level        (level),
    .scalar_event (scalar_event),
    .stamp        (stamp),
    .cfg          (cfg),
    .q_full       (full),
    .push         (push),
    .push_entry   (push_entry)
  );

  vtfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  vtfc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .column       (column),
    .row          (row),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .write_valid  (write_valid),
    .frame_number (frame_number)
  );

endmodule

`default_nettype wire
